// ===== hw/rtl/ifd_pkg.sv =====
// shared types, widths and helpers for the interpolated feedback delay unit
package ifd_pkg;

    // delay line geometry (depth must be a power of two)
    localparam int DEPTH  = 4096;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FRAC_W = 16;
    localparam int POS_W  = ADDR_W + FRAC_W;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int DELAY_W  = 29;
    localparam int GAIN_W   = 16;

    // stream and configuration port widths
    localparam int S_TDATA_W  = 72;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 29;

    // position of each input field inside tdata / tuser
    localparam int SAMPLE_LSB = 0;
    localparam int DTIME_LSB  = SAMPLE_LSB + SAMPLE_W;
    localparam int GAIN_LSB   = DTIME_LSB + DELAY_W;
    localparam int USER_DOVR  = 0;
    localparam int USER_FOVR  = 1;

    // full delay line length in Q13.16
    localparam logic [DELAY_W-1:0] POS_FULL =
        DELAY_W'(longint'(DEPTH) * (longint'(1) << FRAC_W));

    // interpolation and feedback arithmetic widths
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int IPROD_W  = DIFF_W + FRAC_W + 1;
    localparam int FPROD_W  = SAMPLE_W + GAIN_W;
    localparam int WIDE_W   = SAMPLE_W + 3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_DELAY    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_FEEDBACK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_MUL_IP,
        ST_OUT,
        ST_MUL_FB,
        ST_WRITE
    } t_state;

    // clamp a wide signed value into the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(signed'((longint'(1) << (SAMPLE_W - 1)) - 1));
        lo = -(WIDE_W'(signed'(longint'(1) << (SAMPLE_W - 1))));
        if (v > hi) begin
            return hi[SAMPLE_W-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_W-1:0];
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/interpolated_feedback_delay_unit.sv =====
// top level of the interpolated feedback delay unit (feedback comb with fractional delay)
//
// Each input word carries one audio sample, optionally with its own delay (unsigned Q13.16
// samples, clamped to the 4096-sample line) and feedback gain (signed Q1.15) in place of the
// configured defaults. The unit reads the two taps around the fractional read position from a
// single 4096 x 24 synchronous RAM, interpolates linearly with round-half-up, and sends that
// value (saturated to 24 bits) out. It then writes sample + out * gain, rounded and saturated,
// back at the write pointer. An accepted word steps through RD_A, RD_B, MUL_IP, OUT (result
// word loaded into the output register), MUL_FB, WRITE (write-back) and back to IDLE to take
// the next word. The two tap reads share the one RAM read port and are issued one after the
// other, and each of the two multiplies gets a register stage. A new word is accepted only
// once the previous write-back is done; the result sits in an output register, so a stalled
// output holds the next item only at the point where its result is ready. No clearing pass
// is needed after reset: the write pointer doubles as a fill count, and entries not yet
// written read as zero.
// Configuration writes are only legal while the unit is idle.
module interpolated_feedback_delay_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: sample_in[23:0], delay_time[52:24], gain_in[68:53], zero pad[71:69]
    input  logic [ifd_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: delay_override[0], feedback_override[1]
    input  logic [ifd_pkg::S_TUSER_W-1:0]    s_tuser,
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: sample_out[23:0]
    output logic [ifd_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [ifd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [ifd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // delay line ram
    logic [ifd_pkg::SAMPLE_W-1:0] r_mem [ifd_pkg::DEPTH];

    // control state
    ifd_pkg::t_state r_state, n_state;
    logic [ifd_pkg::ADDR_W-1:0]  r_wp;
    logic                        r_full;        // every entry written at least once
    logic                        r_out_valid;

    // configuration
    logic [ifd_pkg::DELAY_W-1:0]        r_base_delay;
    logic signed [ifd_pkg::GAIN_W-1:0]  r_base_fb;

    // per-item payload
    logic signed [ifd_pkg::SAMPLE_W-1:0] r_sample;
    logic signed [ifd_pkg::GAIN_W-1:0]   r_gain;
    logic [ifd_pkg::POS_W-1:0]           r_pos;
    logic signed [ifd_pkg::SAMPLE_W-1:0] r_va;
    logic [ifd_pkg::SAMPLE_W-1:0]        r_rdata;
    logic                                r_rd_ok;   // read entry has been written
    logic signed [ifd_pkg::IPROD_W-1:0]  r_iprod;
    logic signed [ifd_pkg::SAMPLE_W-1:0] r_y;
    logic signed [ifd_pkg::FPROD_W-1:0]  r_fprod;
    logic [ifd_pkg::M_TDATA_W-1:0]       r_out_data;

    // control strobes
    logic w_accept;
    logic w_out_load;
    logic w_mem_we;

    // read position at acceptance
    logic [ifd_pkg::DELAY_W-1:0] w_delay_sel;
    logic [ifd_pkg::DELAY_W-1:0] w_delay_clamp;
    logic [ifd_pkg::DELAY_W-1:0] w_pos_diff;

    // tap addresses
    logic [ifd_pkg::ADDR_W-1:0]  w_tap_a;
    logic [ifd_pkg::ADDR_W-1:0]  w_tap_b;
    logic [ifd_pkg::ADDR_W-1:0]  w_rd_addr;

    // interpolation
    logic signed [ifd_pkg::SAMPLE_W-1:0] w_vb;
    logic signed [ifd_pkg::DIFF_W-1:0]   w_diff;
    logic signed [ifd_pkg::FRAC_W:0]     w_frac;
    logic signed [ifd_pkg::IPROD_W-1:0]  w_iprod;
    logic signed [ifd_pkg::IPROD_W-1:0]  w_iprod_rnd;
    logic signed [ifd_pkg::WIDE_W-1:0]   w_y_wide;
    logic signed [ifd_pkg::SAMPLE_W-1:0] w_y;

    // feedback
    logic signed [ifd_pkg::FPROD_W-1:0]  w_fprod_rnd;
    logic signed [ifd_pkg::WIDE_W-1:0]   w_w_wide;
    logic signed [ifd_pkg::SAMPLE_W-1:0] w_w;

    // ---------------------------------------------------------------- control

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ifd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        s_tready   = 1'b0;
        w_out_load = 1'b0;
        w_mem_we   = 1'b0;
        w_rd_addr  = w_tap_b;
        case (r_state)
            ifd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    n_state = ifd_pkg::ST_RD_A;
                end
            end
            ifd_pkg::ST_RD_A: begin
                w_rd_addr = w_tap_a;
                n_state   = ifd_pkg::ST_RD_B;
            end
            ifd_pkg::ST_RD_B: begin
                // tap a data returns while tap b is issued
                n_state = ifd_pkg::ST_MUL_IP;
            end
            ifd_pkg::ST_MUL_IP: begin
                n_state = ifd_pkg::ST_OUT;
            end
            ifd_pkg::ST_OUT: begin
                // hold here while the previous word still waits at the output
                if (!r_out_valid || m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = ifd_pkg::ST_MUL_FB;
                end
            end
            ifd_pkg::ST_MUL_FB: begin
                n_state = ifd_pkg::ST_WRITE;
            end
            ifd_pkg::ST_WRITE: begin
                w_mem_we = 1'b1;
                n_state  = ifd_pkg::ST_IDLE;
            end
            default: begin
                n_state = ifd_pkg::ST_IDLE;
            end
        endcase
    end

    assign w_accept = s_tvalid && s_tready;

    // ---------------------------------------------------------------- configuration

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_delay <= '0;
            r_base_fb    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ifd_pkg::CFG_BASE_DELAY:    r_base_delay <= i_cfg_data;
                ifd_pkg::CFG_BASE_FEEDBACK: r_base_fb    <= i_cfg_data[ifd_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- read position

    assign w_delay_sel   = s_tuser[ifd_pkg::USER_DOVR]
                         ? s_tdata[ifd_pkg::DTIME_LSB +: ifd_pkg::DELAY_W]
                         : r_base_delay;
    // anything past the full line length reads the entry at the write pointer
    assign w_delay_clamp = (w_delay_sel > ifd_pkg::POS_FULL) ? ifd_pkg::POS_FULL
                                                             : w_delay_sel;
    // modular subtract: the line length is a power of two
    assign w_pos_diff    = ifd_pkg::DELAY_W'({r_wp, {ifd_pkg::FRAC_W{1'b0}}}) - w_delay_clamp;

    assign w_tap_a = r_pos[ifd_pkg::POS_W-1:ifd_pkg::FRAC_W];
    assign w_tap_b = (w_tap_a == ifd_pkg::ADDR_W'(ifd_pkg::DEPTH - 1)) ? '0
                                                                     : w_tap_a + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= s_tdata[ifd_pkg::SAMPLE_LSB +: ifd_pkg::SAMPLE_W];
            r_gain   <= s_tuser[ifd_pkg::USER_FOVR]
                      ? s_tdata[ifd_pkg::GAIN_LSB +: ifd_pkg::GAIN_W]
                      : r_base_fb;
            r_pos    <= w_pos_diff[ifd_pkg::POS_W-1:0];
        end
    end

    // ---------------------------------------------------------------- delay ram

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wp] <= w_w;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // entries below the write pointer are filled until the first wrap
    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_full || (w_rd_addr < r_wp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (w_mem_we) begin
            if (r_wp == ifd_pkg::ADDR_W'(ifd_pkg::DEPTH - 1)) begin
                r_wp   <= '0;
                r_full <= 1'b1;
            end else begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- interpolation

    assign w_vb        = r_rd_ok ? r_rdata : '0;
    assign w_diff      = ifd_pkg::DIFF_W'(w_vb) - ifd_pkg::DIFF_W'(r_va);
    assign w_frac      = {1'b0, r_pos[ifd_pkg::FRAC_W-1:0]};
    assign w_iprod     = w_diff * w_frac;
    assign w_iprod_rnd = (r_iprod + ifd_pkg::IPROD_W'(1 << (ifd_pkg::FRAC_W - 1)))
                         >>> ifd_pkg::FRAC_W;
    assign w_y_wide    = ifd_pkg::WIDE_W'(r_va) + ifd_pkg::WIDE_W'(w_iprod_rnd);
    assign w_y         = ifd_pkg::sat_sample(w_y_wide);

    always_ff @(posedge i_clk) begin
        if (r_state == ifd_pkg::ST_RD_B) begin
            r_va <= r_rd_ok ? r_rdata : '0;
        end
        if (r_state == ifd_pkg::ST_MUL_IP) begin
            r_iprod <= w_iprod;
        end
        if (w_out_load) begin
            r_y <= w_y;
        end
    end

    // ---------------------------------------------------------------- feedback

    assign w_fprod_rnd = (r_fprod + ifd_pkg::FPROD_W'(1 << (ifd_pkg::GAIN_W - 2)))
                         >>> (ifd_pkg::GAIN_W - 1);
    assign w_w_wide    = ifd_pkg::WIDE_W'(r_sample) + ifd_pkg::WIDE_W'(w_fprod_rnd);
    assign w_w         = ifd_pkg::sat_sample(w_w_wide);

    always_ff @(posedge i_clk) begin
        if (r_state == ifd_pkg::ST_MUL_FB) begin
            r_fprod <= r_y * r_gain;
        end
    end

    // ---------------------------------------------------------------- output register

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_y;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

// ===== hw/rtl/ifd_checker.sv =====
// port-level checks for the interpolated feedback delay unit and their bind
module ifd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ifd_pkg::M_TDATA_W-1:0] m_tdata
);

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    // a stalled result word holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    // one item at a time: no acceptance right after an acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back-to-back cycles");

    // a new result only appears while an item is in flight
    a_out_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared with no item in flight");

endmodule

bind interpolated_feedback_delay_unit ifd_checker u_ifd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
